// ===== hw/rtl/sparse_polynomial_adder_macros.svh =====
// Assertion macros for the sparse polynomial adder checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef SPARSE_POLYNOMIAL_ADDER_MACROS_SVH
`define SPARSE_POLYNOMIAL_ADDER_MACROS_SVH

// same-cycle implication
`define SPA_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SPA_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/spa_pkg.sv =====
// Shared types and constants for the sparse polynomial adder.
// No dependencies; imported by every module of the block but the RAM.
`timescale 1ns / 1ps

package spa_pkg;

  localparam int DEG_W       = 15;
  localparam int COEF_W      = 32;
  localparam int IN_TDATA_W  = 48;
  localparam int IN_TUSER_W  = 3;
  localparam int OUT_TDATA_W = 48;
  localparam int OUT_TUSER_W = 3;

  localparam logic [COEF_W-1:0] COEF_MAX = 32'h7FFF_FFFF;
  localparam logic [COEF_W-1:0] COEF_MIN = 32'h8000_0000;

  // request codes
  localparam logic [1:0] REQ_LOAD  = 2'd0;
  localparam logic [1:0] REQ_SUM   = 2'd1;
  localparam logic [1:0] REQ_CLEAR = 2'd2;
  localparam logic [1:0] REQ_RSVD  = 2'd3;

  // status codes
  localparam logic [1:0] STAT_OK   = 2'd0;
  localparam logic [1:0] STAT_BAD  = 2'd1;
  localparam logic [1:0] STAT_FULL = 2'd2;

  typedef struct packed {
    logic [DEG_W-1:0]  degree;
    logic [COEF_W-1:0] coef;
  } term_t;

  typedef struct packed {
    logic              gt;   // x degree above y degree
    logic              eq;   // degrees match
    logic [COEF_W-1:0] sum;  // saturated x + y coefficient
  } alu_res_t;

  typedef struct packed {
    logic       en;
    logic [1:0] status;
    logic       term_valid;
    term_t      term;
    logic       last;
  } push_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_L_RD,
    S_L_CMP,
    S_L_POS,
    S_L_SH,
    S_L_SHW,
    S_M_RD,
    S_M_EV,
    S_M_END,
    S_RESP
  } seq_state_t;

endpackage

// ===== hw/rtl/spa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module spa_ram #(
  parameter int WIDTH = 47,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hw/rtl/spa_alu.sv =====
// Shared compare and saturating-add unit for loads and the merge walk.
// Depends on spa_pkg.
`timescale 1ns / 1ps

module spa_alu
  import spa_pkg::*;
(
  input  term_t    x,
  input  term_t    y,
  output alu_res_t res
);

  logic [COEF_W:0] wide;

  assign wide = {x.coef[COEF_W-1], x.coef} + {y.coef[COEF_W-1], y.coef};

  always_comb begin
    res.gt = x.degree > y.degree;
    res.eq = x.degree == y.degree;
    if (wide[COEF_W] != wide[COEF_W-1]) begin
      res.sum = wide[COEF_W] ? COEF_MIN : COEF_MAX;
    end else begin
      res.sum = wide[COEF_W-1:0];
    end
  end

endmodule

// ===== hw/rtl/spa_seq.sv =====
// Sequencer: sorted insert, merge walk, clear and response beats.
// Depends on spa_pkg; drives both term RAMs and the shared ALU.
`timescale 1ns / 1ps

module spa_seq
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = 16,
  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1,
  localparam int CW = $clog2(MAX_TERMS + 1)
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_req,
  input  logic              in_which,
  input  logic [COEF_W-1:0] in_coef,
  input  logic [15:0]       in_degree,
  input  logic              can_push,
  output push_t             push,
  output logic [AW-1:0]     a_raddr,
  output logic [AW-1:0]     b_raddr,
  input  term_t             a_rdata,
  input  term_t             b_rdata,
  output logic              a_we,
  output logic              b_we,
  output logic [AW-1:0]     waddr,
  output term_t             wdata,
  output term_t             alu_x,
  output term_t             alu_y,
  input  alu_res_t          alu_res
);

  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_TERMS);

  seq_state_t state, state_next;

  logic          which, which_next;
  term_t         t_new, t_new_next;
  logic [CW-1:0] idx, idx_next;
  logic [CW-1:0] ib, ib_next;
  logic [CW-1:0] pos, pos_next;
  logic [CW-1:0] count_a, count_a_next;
  logic [CW-1:0] count_b, count_b_next;
  logic          pend_valid, pend_valid_next;
  term_t         pend, pend_next;
  logic [1:0]    resp, resp_next;

  logic [CW-1:0] cnt_sel;
  term_t         sel_rdata;
  logic [CW-1:0] rd_ptr;
  logic          a_has, b_has, take_a, take_both, mrg_zero;
  term_t         mrg_term;

  assign cnt_sel   = which ? count_b : count_a;
  assign sel_rdata = which ? b_rdata : a_rdata;

  // shift pass reads the entry below the one it writes
  assign rd_ptr  = (state == S_L_SH) ? (idx - CW'(1)) : idx;
  assign a_raddr = rd_ptr[AW-1:0];
  assign b_raddr = (state == S_M_RD || state == S_M_EV) ? ib[AW-1:0] : rd_ptr[AW-1:0];

  assign alu_x = (state == S_M_EV) ? a_rdata : sel_rdata;
  assign alu_y = (state == S_M_EV) ? b_rdata : t_new;

  // merge pick
  assign a_has     = idx < count_a;
  assign b_has     = ib < count_b;
  assign take_both = a_has && b_has && alu_res.eq;
  assign take_a    = !b_has || (a_has && alu_res.gt);
  assign mrg_term.degree = (take_a || take_both) ? a_rdata.degree : b_rdata.degree;
  assign mrg_term.coef   = take_both ? alu_res.sum : (take_a ? a_rdata.coef : b_rdata.coef);
  assign mrg_zero        = mrg_term.coef == '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count_a    <= '0;
      count_b    <= '0;
      pend_valid <= 1'b0;
    end else begin
      count_a    <= count_a_next;
      count_b    <= count_b_next;
      pend_valid <= pend_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    which <= which_next;
    t_new <= t_new_next;
    idx   <= idx_next;
    ib    <= ib_next;
    pos   <= pos_next;
    pend  <= pend_next;
    resp  <= resp_next;
  end

  always_comb begin
    state_next      = state;
    which_next      = which;
    t_new_next      = t_new;
    idx_next        = idx;
    ib_next         = ib;
    pos_next        = pos;
    count_a_next    = count_a;
    count_b_next    = count_b;
    pend_valid_next = pend_valid;
    pend_next       = pend;
    resp_next       = resp;
    in_ready        = 1'b0;
    push            = '0;
    a_we            = 1'b0;
    b_we            = 1'b0;
    waddr           = idx[AW-1:0];
    wdata           = sel_rdata;

    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          unique case (in_req)
            REQ_LOAD: begin
              which_next        = in_which;
              t_new_next.degree = in_degree[DEG_W-1:0];
              t_new_next.coef   = in_coef;
              idx_next          = '0;
              if (in_degree[15] || in_coef == '0) begin
                resp_next  = STAT_BAD;
                state_next = S_RESP;
              end else begin
                state_next = S_L_RD;
              end
            end
            REQ_SUM: begin
              idx_next        = '0;
              ib_next         = '0;
              pend_valid_next = 1'b0;
              state_next      = S_M_RD;
            end
            REQ_CLEAR: begin
              count_a_next = '0;
              count_b_next = '0;
              resp_next    = STAT_OK;
              state_next   = S_RESP;
            end
            REQ_RSVD: begin
              resp_next  = STAT_BAD;
              state_next = S_RESP;
            end
          endcase
        end
      end

      // scan for the first entry not above the new degree
      S_L_RD: begin
        if (idx == cnt_sel) begin
          pos_next   = idx;
          state_next = S_L_POS;
        end else begin
          state_next = S_L_CMP;
        end
      end

      S_L_CMP: begin
        if (alu_res.eq) begin
          resp_next  = STAT_BAD;
          state_next = S_RESP;
        end else if (alu_res.gt) begin
          idx_next   = idx + CW'(1);
          state_next = S_L_RD;
        end else begin
          pos_next   = idx;
          state_next = S_L_POS;
        end
      end

      S_L_POS: begin
        if (cnt_sel == MAX_CNT) begin
          resp_next  = STAT_FULL;
          state_next = S_RESP;
        end else begin
          idx_next   = cnt_sel;
          state_next = S_L_SH;
        end
      end

      // open a slot at pos, top entry first
      S_L_SH: begin
        if (idx == pos) begin
          waddr = pos[AW-1:0];
          wdata = t_new;
          a_we  = !which;
          b_we  = which;
          if (which) begin
            count_b_next = count_b + CW'(1);
          end else begin
            count_a_next = count_a + CW'(1);
          end
          resp_next  = STAT_OK;
          state_next = S_RESP;
        end else begin
          state_next = S_L_SHW;
        end
      end

      S_L_SHW: begin
        waddr      = idx[AW-1:0];
        wdata      = sel_rdata;
        a_we       = !which;
        b_we       = which;
        idx_next   = idx - CW'(1);
        state_next = S_L_SH;
      end

      S_M_RD: begin
        if (!a_has && !b_has) begin
          state_next = S_M_END;
        end else begin
          state_next = S_M_EV;
        end
      end

      // one term held back so the final beat can carry last
      S_M_EV: begin
        if (!(!mrg_zero && pend_valid && !can_push)) begin
          if (!mrg_zero) begin
            if (pend_valid) begin
              push.en         = 1'b1;
              push.status     = STAT_OK;
              push.term_valid = 1'b1;
              push.term       = pend;
              push.last       = 1'b0;
            end
            pend_next       = mrg_term;
            pend_valid_next = 1'b1;
          end
          if (take_a || take_both) begin
            idx_next = idx + CW'(1);
          end
          if (!take_a) begin
            ib_next = ib + CW'(1);
          end
          state_next = S_M_RD;
        end
      end

      S_M_END: begin
        if (can_push) begin
          push.en         = 1'b1;
          push.status     = STAT_OK;
          push.term_valid = pend_valid;
          push.term       = pend_valid ? pend : '0;
          push.last       = 1'b1;
          pend_valid_next = 1'b0;
          state_next      = S_IDLE;
        end
      end

      S_RESP: begin
        if (can_push) begin
          push.en         = 1'b1;
          push.status     = resp;
          push.term_valid = 1'b0;
          push.term       = '0;
          push.last       = 1'b1;
          state_next      = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ===== hw/rtl/sparse_polynomial_adder.sv =====
// One request at a time; each store entry touched takes a read state and then a compare,
//   evaluate or write state, set by the single read port and registered read of each term
//   RAM feeding the shared compare/add unit.
// Reset: synchronous, clears both term counts and the output valid flag; RAM contents stay
//   undefined and are never read below an unwritten count, so no clearing pass is needed.
`timescale 1ns / 1ps

module sparse_polynomial_adder
  import spa_pkg::*;
#(
  parameter int MAX_TERMS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  // request stream
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [31:0] term_coef, [47:32] term_degree
  input  logic [IN_TUSER_W-1:0]  s_tuser,   // [1:0] req_type, [2] which_poly
  // result stream
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [31:0] sum_coef, [46:32] sum_degree, [47] zero
  output logic [OUT_TUSER_W-1:0] m_tuser,   // [1:0] status, [2] term_valid
  output logic                   m_tlast    // last
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;

  // RAM ports
  logic [AW-1:0] a_raddr, b_raddr, waddr;
  logic          a_we, b_we;
  term_t         a_rdata, b_rdata, wdata;

  // shared unit
  term_t    alu_x, alu_y;
  alu_res_t alu_res;

  // output register
  push_t push;
  push_t out_beat;
  logic  out_valid;
  logic  can_push;

  assign can_push = !out_valid || m_tready;

  spa_ram #(
    .WIDTH ($bits(term_t)),
    .DEPTH (MAX_TERMS)
  ) u_ram_a (
    .clk   (clk),
    .we    (a_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (a_raddr),
    .rdata (a_rdata)
  );

  spa_ram #(
    .WIDTH ($bits(term_t)),
    .DEPTH (MAX_TERMS)
  ) u_ram_b (
    .clk   (clk),
    .we    (b_we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  spa_alu u_alu (
    .x   (alu_x),
    .y   (alu_y),
    .res (alu_res)
  );

  spa_seq #(
    .MAX_TERMS (MAX_TERMS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser[1:0]),
    .in_which  (s_tuser[2]),
    .in_coef   (s_tdata[31:0]),
    .in_degree (s_tdata[47:32]),
    .can_push  (can_push),
    .push      (push),
    .a_raddr   (a_raddr),
    .b_raddr   (b_raddr),
    .a_rdata   (a_rdata),
    .b_rdata   (b_rdata),
    .a_we      (a_we),
    .b_we      (b_we),
    .waddr     (waddr),
    .wdata     (wdata),
    .alu_x     (alu_x),
    .alu_y     (alu_y),
    .alu_res   (alu_res)
  );

  // output stage: holds one beat, refilled in the cycle it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push.en) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push.en) begin
      out_beat <= push;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {1'b0, out_beat.term.degree, out_beat.term.coef};
  assign m_tuser  = {out_beat.term_valid, out_beat.status};
  assign m_tlast  = out_beat.last;

endmodule

// ===== hw/rtl/spa_checker.sv =====
// Port-level checker for the sparse polynomial adder, bound to the top level.
// Depends on spa_pkg and sparse_polynomial_adder_macros.svh.
`timescale 1ns / 1ps
`include "sparse_polynomial_adder_macros.svh"

module spa_checker
  import spa_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_tvalid,
  input logic                   s_tready,
  input logic                   m_tvalid,
  input logic                   m_tready,
  input logic [OUT_TDATA_W-1:0] m_tdata,
  input logic [OUT_TUSER_W-1:0] m_tuser,
  input logic                   m_tlast
);

  // a stalled result beat keeps its payload
  `SPA_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast), "result beat changed while stalled")

  // one request at a time: busy right after a request beat
  `SPA_ASSERT_NXT(a_busy_after_req, clk, rst, s_tvalid && s_tready, !s_tready, "request accepted while busy")

  // beats without a term carry zero payload and close the request
  `SPA_ASSERT_IMP(a_empty_beat, clk, rst, m_tvalid && !m_tuser[2], m_tdata == '0 && m_tlast, "non-term beat has payload or no last")

  // term beats only come from a sum and report ok
  `SPA_ASSERT_IMP(a_term_ok, clk, rst, m_tvalid && m_tuser[2], m_tuser[1:0] == STAT_OK, "term beat with non-ok status")

endmodule

bind sparse_polynomial_adder spa_checker u_spa_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

// ===== tb/poly_sum_check_pkg.sv =====
// Result checking for the sparse polynomial adder testbench: term stores mirror and beat compare.
// Depends on spa_pkg for field widths, request and status codes.
`timescale 1ns / 1ps

package poly_sum_check_pkg;
  import spa_pkg::*;

  localparam int TERM_CAP = 16;

  typedef struct packed {
    logic [1:0]        status;
    logic              term_valid;
    logic [COEF_W-1:0] coef;
    logic [DEG_W-1:0]  degree;
    logic              last;
  } sum_beat_t;

  class poly_sum_scoreboard;
    logic [DEG_W-1:0]         degs[2][TERM_CAP];
    logic signed [COEF_W-1:0] coefs[2][TERM_CAP];
    int                       cnt[2];
    sum_beat_t                awaited_beats[$];
    int                       mismatches;

    function new();
      cnt[0] = 0;
      cnt[1] = 0;
      mismatches = 0;
    endfunction

    function int pending();
      return awaited_beats.size();
    endfunction

    function sum_beat_t plain_beat(logic [1:0] st);
      sum_beat_t b;
      b = '0;
      b.status = st;
      b.last = 1'b1;
      return b;
    endfunction

    function logic signed [COEF_W-1:0] clamp_add(logic signed [COEF_W-1:0] x,
                                                 logic signed [COEF_W-1:0] y);
      longint s;
      s = longint'(x) + longint'(y);
      if (s > 64'sd2147483647) return COEF_MAX;
      if (s < -64'sd2147483648) return COEF_MIN;
      return s[COEF_W-1:0];
    endfunction

    // sorted insert, invalid checks ahead of the full check
    function logic [1:0] insert_term(int p, logic signed [COEF_W-1:0] c, logic [15:0] d);
      int pos;
      if (d[15] || c == 0) return STAT_BAD;
      for (int i = 0; i < cnt[p]; i++)
        if (degs[p][i] == d[DEG_W-1:0]) return STAT_BAD;
      if (cnt[p] >= TERM_CAP) return STAT_FULL;
      pos = 0;
      while (pos < cnt[p] && degs[p][pos] > d[DEG_W-1:0]) pos++;
      for (int i = cnt[p]; i > pos; i--) begin
        degs[p][i] = degs[p][i-1];
        coefs[p][i] = coefs[p][i-1];
      end
      degs[p][pos] = d[DEG_W-1:0];
      coefs[p][pos] = c;
      cnt[p]++;
      return STAT_OK;
    endfunction

    function void merge_stores();
      int ia, ib;
      logic [DEG_W-1:0] dg;
      logic signed [COEF_W-1:0] s;
      sum_beat_t terms[$];
      sum_beat_t b;
      ia = 0;
      ib = 0;
      while (ia < cnt[0] || ib < cnt[1]) begin
        if (ib >= cnt[1] || (ia < cnt[0] && degs[0][ia] > degs[1][ib])) begin
          dg = degs[0][ia];
          s = coefs[0][ia];
          ia++;
        end else if (ia >= cnt[0] || degs[1][ib] > degs[0][ia]) begin
          dg = degs[1][ib];
          s = coefs[1][ib];
          ib++;
        end else begin
          dg = degs[0][ia];
          s = clamp_add(coefs[0][ia], coefs[1][ib]);
          ia++;
          ib++;
        end
        if (s != 0) begin
          b = '0;
          b.status = STAT_OK;
          b.term_valid = 1'b1;
          b.coef = s;
          b.degree = dg;
          terms.push_back(b);
        end
      end
      if (terms.size() == 0) begin
        awaited_beats.push_back(plain_beat(STAT_OK));
      end else begin
        terms[terms.size()-1].last = 1'b1;
        foreach (terms[i]) awaited_beats.push_back(terms[i]);
      end
    endfunction

    // called once per accepted request beat
    function void note_request(logic [1:0] req, logic sel, logic [31:0] c, logic [15:0] d);
      case (req)
        REQ_LOAD: awaited_beats.push_back(plain_beat(insert_term(int'(sel), c, d)));
        REQ_SUM: merge_stores();
        REQ_CLEAR: begin
          cnt[0] = 0;
          cnt[1] = 0;
          awaited_beats.push_back(plain_beat(STAT_OK));
        end
        default: awaited_beats.push_back(plain_beat(STAT_BAD));
      endcase
    endfunction

    task report(string msg);
      $display("%0t ns mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task check_beat(sum_beat_t got);
      sum_beat_t want;
      if (awaited_beats.size() == 0) begin
        report($sformatf("result beat with none outstanding: %p", got));
      end else begin
        want = awaited_beats.pop_front();
        if (got.status !== want.status)
          report($sformatf("status %0d, expected %0d", got.status, want.status));
        if (got.term_valid !== want.term_valid)
          report($sformatf("term_valid %0b, expected %0b", got.term_valid, want.term_valid));
        if (got.coef !== want.coef)
          report($sformatf("sum_coef %08h, expected %08h", got.coef, want.coef));
        if (got.degree !== want.degree)
          report($sformatf("sum_degree %0d, expected %0d", got.degree, want.degree));
        if (got.last !== want.last)
          report($sformatf("last %0b, expected %0b", got.last, want.last));
      end
    endtask
  endclass

endpackage

// ===== tb/tb_sparse_polynomial_adder.sv =====
// Top-level testbench of the sparse polynomial adder: directed and random requests under idling.
// Depends on spa_pkg, poly_sum_check_pkg and the sparse_polynomial_adder RTL.
`timescale 1ns / 1ps

module tb_sparse_polynomial_adder;
  import spa_pkg::*;
  import poly_sum_check_pkg::*;

  localparam int ITEM_TARGET    = 500;
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no beat on either side
  localparam int TAIL_CYCLES    = 100;   // idle time after the final drain

  logic                   clk;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;   // [31:0] term_coef, [47:32] term_degree
  logic [IN_TUSER_W-1:0]  s_tuser = '0;   // [1:0] req_type, [2] which_poly
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;        // [31:0] sum_coef, [46:32] sum_degree, [47] zero
  logic [OUT_TUSER_W-1:0] m_tuser;        // [1:0] status, [2] term_valid
  logic                   m_tlast;

  int gap_pct = 0;     // chance per cycle that the request side holds off
  int stall_pct = 0;   // chance per cycle that the result side drops tready
  int items_sent = 0;
  int quiet_cycles = 0;

  poly_sum_scoreboard sb = new();

  sparse_polynomial_adder #(
    .MAX_TERMS(TERM_CAP)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata),
    .m_tuser (m_tuser),
    .m_tlast (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // result-side backpressure
  always @(posedge clk) begin
    m_tready <= !rst && ($urandom_range(99) >= stall_pct);
  end

  // result monitor and watchdog; values read here are the pre-edge ones
  always @(posedge clk) begin
    sum_beat_t got;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        got.status     = m_tuser[1:0];
        got.term_valid = m_tuser[2];
        got.coef       = m_tdata[31:0];
        got.degree     = m_tdata[46:32];
        got.last       = m_tlast;
        sb.check_beat(got);
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
          $display("timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  // one request beat, with random hold-off ahead of it
  task automatic send_req(logic [1:0] req, logic sel, logic [31:0] coef, logic [15:0] deg);
    while ($urandom_range(99) < gap_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= {sel, req};
    s_tdata  <= {deg, coef};
    do @(posedge clk); while (!s_tready);
    sb.note_request(req, sel, coef, deg);
    items_sent++;
  endtask

  // hold the request side until every outstanding result beat is back
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] pick_coef();
    int v;
    case ($urandom_range(9))
      0: return COEF_MAX;
      1: return COEF_MIN;
      2: return 32'd0;
      3, 4: return $urandom();
      default: begin
        // small whole values so matched degrees cancel now and then
        v = int'($urandom_range(6)) - 3;
        return 32'(v * 65536);
      end
    endcase
  endfunction

  // spread mode uses the whole degree range: few collisions, stores fill up
  function automatic logic [15:0] pick_degree(bit spread);
    case ($urandom_range(19))
      0: return 16'($urandom()) | 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($urandom_range(32767));
      default: return spread ? 16'($urandom_range(32767)) : 16'($urandom_range(23));
    endcase
  endfunction

  // usually a clear, then a run of loads with a little noise mixed in, then a sum
  task automatic run_sequence();
    int n;
    bit spread;
    spread = ($urandom_range(3) == 0);
    if ($urandom_range(9) < 7)
      send_req(REQ_CLEAR, 1'($urandom_range(1)), $urandom(), 16'($urandom()));
    n = $urandom_range(40);
    repeat (n) begin
      case ($urandom_range(39))
        0: send_req(REQ_RSVD, 1'($urandom_range(1)), $urandom(), 16'($urandom()));
        1: send_req(REQ_SUM, 1'($urandom_range(1)), $urandom(), 16'($urandom()));
        default: send_req(REQ_LOAD, 1'($urandom_range(1)), pick_coef(), pick_degree(spread));
      endcase
    end
    send_req(REQ_SUM, 1'($urandom_range(1)), $urandom(), 16'($urandom()));
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty sum, rejects, extremes, saturation both ways, cancel
    send_req(REQ_SUM, 1'b0, 32'd0, 16'd0);
    send_req(REQ_LOAD, 1'b0, 32'h0001_0000, 16'd0);
    send_req(REQ_LOAD, 1'b0, COEF_MAX, 16'h7FFF);
    send_req(REQ_LOAD, 1'b0, 32'h0002_0000, 16'hFFFF);      // negative degree
    send_req(REQ_LOAD, 1'b1, 32'h0002_0000, 16'h8000);      // most negative degree
    send_req(REQ_LOAD, 1'b0, 32'd0, 16'd7);                 // zero coefficient
    send_req(REQ_LOAD, 1'b0, 32'h0003_0000, 16'd0);         // duplicate degree
    send_req(REQ_LOAD, 1'b1, 32'h0000_0001, 16'h7FFF);      // saturates high
    send_req(REQ_LOAD, 1'b1, 32'hFFFF_0000, 16'd0);         // cancels A's term
    send_req(REQ_LOAD, 1'b1, COEF_MIN, 16'd5);
    send_req(REQ_LOAD, 1'b0, 32'hFFFF_FFFF, 16'd5);         // saturates low
    send_req(REQ_SUM, 1'b0, 32'd0, 16'd0);
    send_req(REQ_RSVD, 1'b1, 32'hFFFF_FFFF, 16'hFFFF);
    send_req(REQ_CLEAR, 1'b0, 32'd0, 16'd0);
    send_req(REQ_SUM, 1'b1, 32'd0, 16'd0);
    drain();

    // random part in four idling phases; each phase ends with a full drain
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin gap_pct = 0;  stall_pct = 0;  end
        1: begin gap_pct = 65; stall_pct = 0;  end
        2: begin gap_pct = 0;  stall_pct = 65; end
        default: begin gap_pct = 14; stall_pct = 14; end
      endcase
      while (items_sent < (ph + 1) * ITEM_TARGET / 4) run_sequence();
      drain();
    end

    gap_pct = 0;
    stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
